>>> src/keypad_code_lock_controller_top_defines.svh
// Assertion macros for the keypad code lock controller.
// Included by keypad_code_lock_controller_top.sv; expects i_clk and i_rst_n in scope.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_TOP_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/kcl_pkg.sv
// Shared types and constants of the keypad code lock controller.
// No dependencies; used by kcl_lock_core and the top level.
package kcl_pkg;

    localparam int CODE_DIGITS_DEF = 4;

    localparam int KEY_W    = 8;
    localparam int TRIAL_W  = 4;
    localparam int TICK_W   = 8;
    localparam int DIGIT_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [KEY_W-1:0]   NO_KEY            = 8'hFF;
    localparam logic [KEY_W-1:0]   RESET_KEY_RST     = 8'd65;
    localparam logic [TRIAL_W-1:0] TRIAL_LIMIT_RST   = 4'd3;
    localparam logic [TICK_W-1:0]  BLOCK_TICKS_RST   = 8'd30;

    typedef enum logic {
        OP_KEY  = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_KEY   = 2'd0,
        CFG_TRIAL_LIMIT = 2'd1,
        CFG_BLOCK_TICKS = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_DIGIT     = 3'd1,
        EV_CODE_SET  = 3'd2,
        EV_VOIDED    = 3'd3,
        EV_CORRECT   = 3'd4,
        EV_WRONG     = 3'd5,
        EV_BLOCKED   = 3'd6,
        EV_UNBLOCKED = 3'd7
    } t_event;

    typedef struct packed {
        logic [KEY_W-1:0]   reset_key;
        logic [TRIAL_W-1:0] trial_limit;
        logic [TICK_W-1:0]  block_ticks;
    } t_cfg;

    typedef struct packed {
        t_event             ev;
        logic [TRIAL_W-1:0] trials_remaining;
        logic [TICK_W-1:0]  block_remaining;
        logic [DIGIT_W-1:0] digits_entered;
        logic               in_setup;
    } t_result;

endpackage

>>> src/kcl_lock_core.sv
// Lock state and its combinational update for one request, registered on i_fire.
// Depends on kcl_pkg.
module kcl_lock_core #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic                          i_opcode,
    input  logic [kcl_pkg::KEY_W-1:0]     i_key,
    input  kcl_pkg::t_cfg                 i_cfg,
    output kcl_pkg::t_result              o_result
);

    localparam int CW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam logic [CW-1:0] LAST = CW'(CODE_DIGITS - 1);

    logic [CODE_DIGITS-1:0][kcl_pkg::KEY_W-1:0] r_code, n_code;
    logic [CODE_DIGITS-1:0][kcl_pkg::KEY_W-1:0] r_buf, n_buf;
    logic                            r_code_valid, n_code_valid;
    logic [CW-1:0]                   r_cnt, n_cnt;
    logic                            r_voided, n_voided;
    logic [kcl_pkg::TRIAL_W-1:0]     r_trials, n_trials;
    logic [kcl_pkg::TICK_W-1:0]      r_lock, n_lock;
    kcl_pkg::t_event                 ev;
    logic                            match;
    logic                            is_reset_key;
    logic [CW+2:0]                   cnt_ext;

    assign is_reset_key = (i_key == i_cfg.reset_key);

    always_comb begin
        n_code       = r_code;
        n_buf        = r_buf;
        n_code_valid = r_code_valid;
        n_cnt        = r_cnt;
        n_voided     = r_voided;
        n_trials     = r_trials;
        n_lock       = r_lock;
        ev           = kcl_pkg::EV_NONE;
        match        = 1'b1;

        if (i_opcode == kcl_pkg::OP_TICK) begin
            if (r_lock != '0) begin
                n_lock = r_lock - 1'b1;
                if (r_lock == 8'd1) begin
                    ev = kcl_pkg::EV_UNBLOCKED;
                end
            end
        end else if (i_key != kcl_pkg::NO_KEY && r_lock == '0) begin
            if (!r_code_valid) begin
                // Setup: the reset key takes a slot but voids the entry.
                if (is_reset_key) begin
                    n_voided = 1'b1;
                end else begin
                    n_buf[r_cnt] = i_key;
                end
                if (r_cnt != LAST) begin
                    n_cnt = CW'(r_cnt + 1'b1);
                    ev    = kcl_pkg::EV_DIGIT;
                end else begin
                    n_cnt = '0;
                    if (n_voided) begin
                        n_voided = 1'b0;
                        ev       = kcl_pkg::EV_VOIDED;
                    end else begin
                        n_code       = n_buf;
                        n_code_valid = 1'b1;
                        ev           = kcl_pkg::EV_CODE_SET;
                    end
                end
            end else if (is_reset_key) begin
                n_code_valid = 1'b0;
                n_cnt        = '0;
                n_voided     = 1'b0;
                ev           = kcl_pkg::EV_VOIDED;
            end else begin
                n_buf[r_cnt] = i_key;
                if (r_cnt != LAST) begin
                    n_cnt = CW'(r_cnt + 1'b1);
                    ev    = kcl_pkg::EV_DIGIT;
                end else begin
                    n_cnt = '0;
                    for (int i = 0; i < CODE_DIGITS; i++) begin
                        if (n_buf[i] != r_code[i]) begin
                            match = 1'b0;
                        end
                    end
                    if (match) begin
                        n_trials = i_cfg.trial_limit;
                        ev       = kcl_pkg::EV_CORRECT;
                    end else if (r_trials <= 4'd1) begin
                        n_trials = i_cfg.trial_limit;
                        n_lock   = i_cfg.block_ticks;
                        ev       = kcl_pkg::EV_BLOCKED;
                    end else begin
                        n_trials = r_trials - 1'b1;
                        ev       = kcl_pkg::EV_WRONG;
                    end
                end
            end
        end
    end

    // Digit buffers hold no reset value; they are only read once written.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_code <= n_code;
            r_buf  <= n_buf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_valid <= 1'b0;
            r_cnt        <= '0;
            r_voided     <= 1'b0;
            r_trials     <= kcl_pkg::TRIAL_LIMIT_RST;
            r_lock       <= '0;
        end else if (i_fire) begin
            r_code_valid <= n_code_valid;
            r_cnt        <= n_cnt;
            r_voided     <= n_voided;
            r_trials     <= n_trials;
            r_lock       <= n_lock;
        end
    end

    assign cnt_ext = {3'b000, n_cnt};

    always_comb begin
        o_result.ev               = ev;
        o_result.trials_remaining = n_trials;
        o_result.block_remaining  = n_lock;
        o_result.digits_entered   = cnt_ext[2:0];
        o_result.in_setup         = ~n_code_valid;
    end

endmodule

>>> src/keypad_code_lock_controller_top.sv
// Top level of the keypad code lock controller: handshake stages and configuration.
// Depends on kcl_pkg, kcl_lock_core and keypad_code_lock_controller_top_defines.svh.
//
// Usage: each input request is a key press (opcode 0, key in i_key_code) or a
// one-second tick (opcode 1). Every request yields exactly one result request
// carrying the event code and the lock status after the update.
// Both channels use valid/ready. A request is taken into an input register when
// accepted; the lock core computes its update from that register and the result
// register loads it once the result slot is free, and from there the result is
// offered on the output channel. While the receiver does not stall, the block
// sustains one request per cycle: the input register frees itself whenever the
// result register is empty or is being drained in the same cycle.
// When the receiver stalls, the result register holds, then the input register
// fills, and only then does o_in_ready fall; no request is lost.
// Configuration is a write-only port (index 0 reset key, 1 trial limit,
// 2 block ticks), to be used while no request is in flight.
// Reset (synchronous, active low) empties both stages, clears the stored code
// flag, the entry count and the lockout, loads the trial count with 3 and
// restores the register defaults (reset key 65, 3 trials, 30 ticks).
`include "keypad_code_lock_controller_top_defines.svh"

module keypad_code_lock_controller_top #(
    parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [kcl_pkg::KEY_W-1:0]         i_key_code,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [2:0]                        o_event_res,
    output logic [kcl_pkg::TRIAL_W-1:0]       o_trials_remaining,
    output logic [kcl_pkg::TICK_W-1:0]        o_block_remaining,
    output logic [kcl_pkg::DIGIT_W-1:0]       o_digits_entered,
    output logic                              o_in_setup,
    input  logic                              i_cfg_we,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kcl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                      r_in_valid;
    logic                      r_opcode;
    logic [kcl_pkg::KEY_W-1:0] r_key;
    logic                      r_out_valid;
    kcl_pkg::t_result          r_out;
    kcl_pkg::t_result          core_result;
    kcl_pkg::t_cfg             r_cfg;
    logic                      proc_fire;
    logic                      in_fire;

    // The core step runs whenever a request waits and the result slot frees.
    assign proc_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_key   <= kcl_pkg::RESET_KEY_RST;
            r_cfg.trial_limit <= kcl_pkg::TRIAL_LIMIT_RST;
            r_cfg.block_ticks <= kcl_pkg::BLOCK_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kcl_pkg::CFG_RESET_KEY:   r_cfg.reset_key   <= i_cfg_data;
                kcl_pkg::CFG_TRIAL_LIMIT: r_cfg.trial_limit <= i_cfg_data[3:0];
                kcl_pkg::CFG_BLOCK_TICKS: r_cfg.block_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_opcode <= i_opcode;
            r_key    <= i_key_code;
        end
    end

    kcl_lock_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proc_fire),
        .i_opcode (r_opcode),
        .i_key    (r_key),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_res        = r_out.ev;
    assign o_trials_remaining = r_out.trials_remaining;
    assign o_block_remaining  = r_out.block_remaining;
    assign o_digits_entered   = r_out.digits_entered;
    assign o_in_setup         = r_out.in_setup;

    // A waiting request is never overwritten before the core has taken it.
    `KCL_ASSERT_NEXT(a_in_hold, r_in_valid && !proc_fire, r_in_valid && $stable(r_key), "input request lost")
    // Unblocking always leaves the lockout counter at zero.
    `KCL_ASSERT_SAME(a_unblock_free, o_out_valid && o_event_res == kcl_pkg::EV_UNBLOCKED, o_block_remaining == 8'd0, "unblock with lockout left")
    // Storing a code ends setup and restarts the digit count.
    `KCL_ASSERT_SAME(a_code_set, o_out_valid && o_event_res == kcl_pkg::EV_CODE_SET, !o_in_setup && o_digits_entered == 3'd0, "code set left setup state")

endmodule
